// ===== rtl/core/ssbd_pkg.sv =====
// Shared types, constants and helper functions for the supersample box downscaler.
// Used by every module under rtl/core; depends on nothing.
package ssbd_pkg;

  // Limits
  localparam int MAX_OUT_WIDTH = 2048;
  localparam int MAX_FACTOR    = 8;
  localparam int HEIGHT_LIMIT  = 4096;

  // Field and counter widths
  localparam int FACTOR_W   = 4;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int PIX_W      = 8;
  localparam int X_W        = 11;
  localparam int Y_W        = 12;
  localparam int COL_W      = 14;
  localparam int KW_W       = 15;
  localparam int CIB_W      = 3;
  localparam int BAND_W     = 12;
  localparam int ROW_SUM_W  = 11;
  localparam int COL_SUM_W  = 14;

  // Reciprocal multipliers: exact floor division for dividends below 2**COL_W
  localparam int RC_W       = 18;
  localparam int RC_SHIFT   = 17;
  localparam int RA_W       = 21;
  localparam int RA_SHIFT   = 20;
  localparam int COL_PROD_W = COL_W + RC_W;
  localparam int AVG_PROD_W = COL_SUM_W + RA_W;

  // Line store
  localparam int MEM_AW     = 11;
  localparam int MEM_DW     = 3 * COL_SUM_W;

  // Block queue between front and back
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [WIDTH_W-1:0]  out_width;
    logic [HEIGHT_W-1:0] out_height;
  } cfg_t;

  // One finished row segment of a block, handed from front to back
  typedef struct packed {
    logic [COL_W-1:0]     src_col;
    logic [ROW_SUM_W-1:0] sum_r;
    logic [ROW_SUM_W-1:0] sum_g;
    logic [ROW_SUM_W-1:0] sum_b;
    logic                 first_row;
    logic                 emit;
    logic [Y_W-1:0]       y;
    logic                 done;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Factor register to block edge: zero acts as one, large values saturate
  function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
    logic [FACTOR_W-1:0] k;
    if (f == '0) begin
      k = FACTOR_W'(1);
    end else if (f > FACTOR_W'(MAX_FACTOR)) begin
      k = FACTOR_W'(MAX_FACTOR);
    end else begin
      k = f;
    end
    return k;
  endfunction

  // ceil(2**17 / k)
  function automatic logic [RC_W-1:0] recip_col(input logic [FACTOR_W-1:0] k);
    logic [RC_W-1:0] r;
    unique case (k)
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  // ceil(2**20 / k**2)
  function automatic logic [RA_W-1:0] recip_avg(input logic [FACTOR_W-1:0] k);
    logic [RA_W-1:0] r;
    unique case (k)
      4'd2:    r = 21'd262144;
      4'd3:    r = 21'd116509;
      4'd4:    r = 21'd65536;
      4'd5:    r = 21'd41944;
      4'd6:    r = 21'd29128;
      4'd7:    r = 21'd21400;
      4'd8:    r = 21'd16384;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/ssbd_front.sv =====
// Front end: position counters and per-row block accumulation.
// Pushes one block segment per block end into the queue; uses ssbd_pkg.
module ssbd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  ssbd_pkg::cfg_t               cfg,
  input  logic                         accept,
  input  logic                         frame_start,
  input  logic [ssbd_pkg::PIX_W-1:0]   src_red,
  input  logic [ssbd_pkg::PIX_W-1:0]   src_green,
  input  logic [ssbd_pkg::PIX_W-1:0]   src_blue,
  output logic                         push,
  output ssbd_pkg::blk_t               blk
);

  logic [ssbd_pkg::COL_W-1:0]     src_column;
  logic [ssbd_pkg::CIB_W-1:0]     column_in_block;
  logic [ssbd_pkg::CIB_W-1:0]     row_in_band;
  logic [ssbd_pkg::BAND_W-1:0]    band_index;
  logic [ssbd_pkg::ROW_SUM_W-1:0] row_r, row_g, row_b;

  logic [ssbd_pkg::FACTOR_W-1:0]  k;
  logic [ssbd_pkg::WIDTH_W-1:0]   w;
  logic [ssbd_pkg::HEIGHT_W-1:0]  h;
  logic [ssbd_pkg::KW_W-1:0]      kw;
  logic [ssbd_pkg::COL_W-1:0]     sc;
  logic [ssbd_pkg::CIB_W-1:0]     cib;
  logic [ssbd_pkg::CIB_W-1:0]     rib;
  logic [ssbd_pkg::BAND_W-1:0]    band;
  logic [ssbd_pkg::ROW_SUM_W-1:0] r_new, g_new, b_new;
  logic                           block_end, band_end, row_end, last_band;

  // Effective geometry
  always_comb begin
    k = ssbd_pkg::eff_factor(cfg.factor);
    if (cfg.out_width == '0) begin
      w = ssbd_pkg::WIDTH_W'(1);
    end else if (cfg.out_width > ssbd_pkg::WIDTH_W'(ssbd_pkg::MAX_OUT_WIDTH)) begin
      w = ssbd_pkg::WIDTH_W'(ssbd_pkg::MAX_OUT_WIDTH);
    end else begin
      w = cfg.out_width;
    end
    if (cfg.out_height == '0) begin
      h = ssbd_pkg::HEIGHT_W'(1);
    end else if (cfg.out_height > ssbd_pkg::HEIGHT_W'(ssbd_pkg::HEIGHT_LIMIT)) begin
      h = ssbd_pkg::HEIGHT_W'(ssbd_pkg::HEIGHT_LIMIT);
    end else begin
      h = cfg.out_height;
    end
    kw = ssbd_pkg::KW_W'(k) * ssbd_pkg::KW_W'(w);
  end

  // Counters as seen by this pixel (frame start clears them first)
  always_comb begin
    sc    = frame_start ? '0 : src_column;
    cib   = frame_start ? '0 : column_in_block;
    rib   = frame_start ? '0 : row_in_band;
    band  = frame_start ? '0 : band_index;
    r_new = (frame_start ? '0 : row_r) + ssbd_pkg::ROW_SUM_W'(src_red);
    g_new = (frame_start ? '0 : row_g) + ssbd_pkg::ROW_SUM_W'(src_green);
    b_new = (frame_start ? '0 : row_b) + ssbd_pkg::ROW_SUM_W'(src_blue);

    block_end = (ssbd_pkg::FACTOR_W'(cib) + ssbd_pkg::FACTOR_W'(1)) >= k;
    band_end  = (ssbd_pkg::FACTOR_W'(rib) + ssbd_pkg::FACTOR_W'(1)) >= k;
    row_end   = (ssbd_pkg::KW_W'(sc) + ssbd_pkg::KW_W'(1)) >= kw;
    last_band = (ssbd_pkg::HEIGHT_W'(band) + ssbd_pkg::HEIGHT_W'(1)) >= h;
  end

  // Block segment request
  always_comb begin
    push          = accept && block_end;
    blk.src_col   = sc;
    blk.sum_r     = r_new;
    blk.sum_g     = g_new;
    blk.sum_b     = b_new;
    blk.first_row = (rib == '0);
    blk.emit      = band_end;
    blk.done      = row_end && last_band;
    if (ssbd_pkg::HEIGHT_W'(band) < h) begin
      blk.y = ssbd_pkg::Y_W'(h - ssbd_pkg::HEIGHT_W'(1) - ssbd_pkg::HEIGHT_W'(band));
    end else begin
      blk.y = '0;
    end
  end

  // Counter and accumulator update
  always_ff @(posedge clk) begin
    if (rst) begin
      src_column      <= '0;
      column_in_block <= '0;
      row_in_band     <= '0;
      band_index      <= '0;
      row_r           <= '0;
      row_g           <= '0;
      row_b           <= '0;
    end else if (accept) begin
      src_column      <= row_end ? '0 : sc + ssbd_pkg::COL_W'(1);
      column_in_block <= (block_end || row_end) ? '0 : cib + ssbd_pkg::CIB_W'(1);
      row_r           <= (block_end || row_end) ? '0 : r_new;
      row_g           <= (block_end || row_end) ? '0 : g_new;
      row_b           <= (block_end || row_end) ? '0 : b_new;
      if (row_end) begin
        if (band_end) begin
          row_in_band <= '0;
          band_index  <= last_band ? '0 : band + ssbd_pkg::BAND_W'(1);
        end else begin
          row_in_band <= rib + ssbd_pkg::CIB_W'(1);
          band_index  <= band;
        end
      end else begin
        row_in_band <= rib;
        band_index  <= band;
      end
    end
  end

endmodule

// ===== rtl/core/ssbd_queue.sv =====
// Short FIFO of block segments between front and back.
// Uses ssbd_pkg for the entry type and depth.
module ssbd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ssbd_pkg::blk_t   push_blk,
  input  logic             pop,
  output ssbd_pkg::blk_t   head,
  output ssbd_pkg::qstat_t stat
);

  ssbd_pkg::blk_t                 entries [ssbd_pkg::QDEPTH];
  logic [ssbd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ssbd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ssbd_pkg::QCNT_W-1:0]    count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == ssbd_pkg::QCNT_W'(ssbd_pkg::QDEPTH));
  assign stat.empty = (count == '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ssbd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ssbd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + ssbd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - ssbd_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_blk;
    end
  end

endmodule

// ===== rtl/core/ssbd_back.sv =====
// Back end: line store read-modify-write and block average.
// Sequencer over column divide, store access and reciprocal multiply; uses ssbd_pkg.
module ssbd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ssbd_pkg::FACTOR_W-1:0] factor,
  input  ssbd_pkg::qstat_t              qstat,
  input  ssbd_pkg::blk_t                head,
  output logic                          pop,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [ssbd_pkg::PIX_W-1:0]    avg_red,
  output logic [ssbd_pkg::PIX_W-1:0]    avg_green,
  output logic [ssbd_pkg::PIX_W-1:0]    avg_blue,
  output logic [ssbd_pkg::X_W-1:0]      out_x,
  output logic [ssbd_pkg::Y_W-1:0]      out_y,
  output logic                          frame_done
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COL  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_AVG  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                          state;
  ssbd_pkg::blk_t                      cur;
  logic [ssbd_pkg::FACTOR_W-1:0]       k;
  logic [ssbd_pkg::COL_PROD_W-1:0]     col_prod;
  logic [ssbd_pkg::MEM_AW-1:0]         x;
  logic [ssbd_pkg::MEM_DW-1:0]         mem [ssbd_pkg::MAX_OUT_WIDTH];
  logic [ssbd_pkg::MEM_DW-1:0]         rd_data;
  logic [ssbd_pkg::COL_SUM_W-1:0]      s_r, s_g, s_b;
  logic [ssbd_pkg::COL_SUM_W-1:0]      sum_r, sum_g, sum_b;
  logic [ssbd_pkg::AVG_PROD_W-1:0]     prod_r, prod_g, prod_b;

  assign k   = ssbd_pkg::eff_factor(factor);
  assign pop = (state == S_IDLE) && !qstat.empty;

  // Column sum: this row's segment plus earlier rows of the band
  always_comb begin
    s_r = ssbd_pkg::COL_SUM_W'(cur.sum_r)
        + (cur.first_row ? '0 : rd_data[2*ssbd_pkg::COL_SUM_W +: ssbd_pkg::COL_SUM_W]);
    s_g = ssbd_pkg::COL_SUM_W'(cur.sum_g)
        + (cur.first_row ? '0 : rd_data[ssbd_pkg::COL_SUM_W +: ssbd_pkg::COL_SUM_W]);
    s_b = ssbd_pkg::COL_SUM_W'(cur.sum_b)
        + (cur.first_row ? '0 : rd_data[0 +: ssbd_pkg::COL_SUM_W]);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (!qstat.empty) state <= S_COL;
        S_COL:  state <= S_ADDR;
        S_ADDR: state <= S_SUM;
        S_SUM:  state <= cur.emit ? S_MUL : S_IDLE;
        S_MUL:  state <= S_AVG;
        S_AVG: begin
          res_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Line store: registered read, write back of the updated sum
  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      rd_data <= mem[col_prod[ssbd_pkg::RC_SHIFT +: ssbd_pkg::MEM_AW]];
    end
    if (state == S_SUM) begin
      mem[x] <= {s_r, s_g, s_b};
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_COL) begin
      col_prod <= ssbd_pkg::COL_PROD_W'(cur.src_col) * ssbd_pkg::COL_PROD_W'(ssbd_pkg::recip_col(k));
    end
    if (state == S_ADDR) begin
      x <= col_prod[ssbd_pkg::RC_SHIFT +: ssbd_pkg::MEM_AW];
    end
    if (state == S_SUM) begin
      sum_r <= s_r;
      sum_g <= s_g;
      sum_b <= s_b;
    end
    if (state == S_MUL) begin
      prod_r <= ssbd_pkg::AVG_PROD_W'(sum_r) * ssbd_pkg::AVG_PROD_W'(ssbd_pkg::recip_avg(k));
      prod_g <= ssbd_pkg::AVG_PROD_W'(sum_g) * ssbd_pkg::AVG_PROD_W'(ssbd_pkg::recip_avg(k));
      prod_b <= ssbd_pkg::AVG_PROD_W'(sum_b) * ssbd_pkg::AVG_PROD_W'(ssbd_pkg::recip_avg(k));
    end
    if (state == S_AVG) begin
      avg_red    <= prod_r[ssbd_pkg::RA_SHIFT +: ssbd_pkg::PIX_W];
      avg_green  <= prod_g[ssbd_pkg::RA_SHIFT +: ssbd_pkg::PIX_W];
      avg_blue   <= prod_b[ssbd_pkg::RA_SHIFT +: ssbd_pkg::PIX_W];
      out_x      <= x;
      out_y      <= cur.y;
      frame_done <= cur.done;
    end
  end

endmodule

// ===== rtl/core/supersample_box_downscaler.sv =====
// Supersample box downscaler. A pixel request is taken each cycle while the block queue
// has room; each block end takes the back end through column divide, line store read and
// write, plus multiply, truncate and output wait when it completes an output pixel.
// Reset (rst, synchronous) clears counters, accumulators and queue and sets the
// configuration registers to 1; the line store is not cleared and each entry is
// written on a band's first row.
module supersample_box_downscaler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  logic                            frame_start,
  input  logic [ssbd_pkg::PIX_W-1:0]      src_red,
  input  logic [ssbd_pkg::PIX_W-1:0]      src_green,
  input  logic [ssbd_pkg::PIX_W-1:0]      src_blue,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [ssbd_pkg::PIX_W-1:0]      avg_red,
  output logic [ssbd_pkg::PIX_W-1:0]      avg_green,
  output logic [ssbd_pkg::PIX_W-1:0]      avg_blue,
  output logic [ssbd_pkg::X_W-1:0]        out_x,
  output logic [ssbd_pkg::Y_W-1:0]        out_y,
  output logic                            frame_done
);

  ssbd_pkg::cfg_t   cfg;
  ssbd_pkg::blk_t   push_blk;
  ssbd_pkg::blk_t   head;
  ssbd_pkg::qstat_t qstat;
  logic             push;
  logic             pop;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign pix_stall = qstat.full;
  assign accept    = pix_valid && !pix_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.factor     <= ssbd_pkg::FACTOR_W'(1);
      cfg.out_width  <= ssbd_pkg::WIDTH_W'(1);
      cfg.out_height <= ssbd_pkg::HEIGHT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssbd_pkg::REG_FACTOR:     cfg.factor     <= cfg_data[ssbd_pkg::FACTOR_W-1:0];
        ssbd_pkg::REG_OUT_WIDTH:  cfg.out_width  <= cfg_data[ssbd_pkg::WIDTH_W-1:0];
        ssbd_pkg::REG_OUT_HEIGHT: cfg.out_height <= cfg_data[ssbd_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  ssbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .frame_start (frame_start),
    .src_red     (src_red),
    .src_green   (src_green),
    .src_blue    (src_blue),
    .push        (push),
    .blk         (push_blk)
  );

  ssbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  ssbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .factor     (cfg.factor),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .avg_red    (avg_red),
    .avg_green  (avg_green),
    .avg_blue   (avg_blue),
    .out_x      (out_x),
    .out_y      (out_y),
    .frame_done (frame_done)
  );

  // No block segment is pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && qstat.full))
    else $error("block pushed into full queue");

  // Queue never pops while empty
  assert property (@(posedge clk) disable iff (rst) !(pop && qstat.empty))
    else $error("block popped from empty queue");

  // The last pixel of a frame sits on the top output row
  assert property (@(posedge clk) disable iff (rst) (res_valid && frame_done) |-> (out_y == '0))
    else $error("frame end not on top row");

  // A taken result is never followed at once by another one
  assert property (@(posedge clk) disable iff (rst) (res_valid && !res_stall) |=> !res_valid)
    else $error("result repeated after handshake");

endmodule
